// ===== rtl/iterative_sigma_clip_threshold_unit_defines.svh =====
`ifndef ITERATIVE_SIGMA_CLIP_THRESHOLD_UNIT_DEFINES_SVH
`define ITERATIVE_SIGMA_CLIP_THRESHOLD_UNIT_DEFINES_SVH

// implication in the same cycle
`define ISCL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("iscl assertion failed");

// implication in the next cycle
`define ISCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("iscl assertion failed");

`endif

// ===== rtl/iscl_pkg.sv =====
`timescale 1ns / 1ps
package iscl_pkg;

	localparam int MAX_PIXELS = 4096;
	localparam int PIXEL_BITS = 16;
	localparam int ADDR_W     = 12;
	localparam int CNT_W      = 13;
	localparam int Q_W        = 24;
	localparam int SUM_W      = 29;
	localparam int SQ_W       = 43;
	localparam int NSIG_W     = 12;
	localparam int PASS_W     = 4;

	localparam logic signed [Q_W-1:0] Q24_MAX = 24'sh7FFFFF;
	localparam logic signed [Q_W-1:0] Q24_MIN = -24'sh800000;

	// input actions
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_COMPUTE = 2'd1;
	localparam logic [1:0] ACT_MASK    = 2'd2;

	// result kinds
	localparam logic KIND_STATS = 1'b0;
	localparam logic KIND_MASK  = 1'b1;

	// register indexes
	localparam logic [1:0] REG_NSIGMA = 2'd0;
	localparam logic [1:0] REG_COUNT  = 2'd1;
	localparam logic [1:0] REG_PASSES = 2'd2;

	localparam logic [NSIG_W-1:0] NSIGMA_RST = 12'd768;
	localparam logic [CNT_W-1:0]  COUNT_RST  = 13'd4096;
	localparam logic [PASS_W-1:0] PASSES_RST = 4'd5;

	typedef struct packed {
		logic [CNT_W-1:0]        n;
		logic signed [SUM_W-1:0] sum;
		logic [SQ_W-1:0]         sq;
	} stats_req_t;

	typedef struct packed {
		logic signed [Q_W-1:0] mean;
		logic [Q_W-1:0]        std;
		logic signed [Q_W-1:0] cut;
	} stats_res_t;

endpackage

// ===== rtl/iscl_pixel_ram.sv =====
`timescale 1ns / 1ps
module iscl_pixel_ram (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [iscl_pkg::ADDR_W-1:0]            waddr,
	input  logic signed [iscl_pkg::PIXEL_BITS-1:0] wdata,
	input  logic                                   re,
	input  logic [iscl_pkg::ADDR_W-1:0]            raddr,
	output logic signed [iscl_pkg::PIXEL_BITS-1:0] rdata
);
	import iscl_pkg::*;

	logic signed [PIXEL_BITS-1:0] mem [MAX_PIXELS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/iscl_stats.sv =====
`timescale 1ns / 1ps
`include "iterative_sigma_clip_threshold_unit_defines.svh"
module iscl_stats (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  iscl_pkg::stats_req_t        req,
	input  logic [iscl_pkg::NSIG_W-1:0] nsigma,
	output logic                        done,
	output iscl_pkg::stats_res_t        res
);
	import iscl_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIVM = 4'd1;
	localparam logic [3:0] S_MFIN = 4'd2;
	localparam logic [3:0] S_DIVA = 4'd3;
	localparam logic [3:0] S_AFIN = 4'd4;
	localparam logic [3:0] S_VAR  = 4'd5;
	localparam logic [3:0] S_SQRT = 4'd6;
	localparam logic [3:0] S_SFIN = 4'd7;
	localparam logic [3:0] S_CUTM = 4'd8;
	localparam logic [3:0] S_CUTA = 4'd9;

	localparam int NUM_W  = 59;
	localparam int ROOT_W = 30;

	logic [3:0]              state_q;
	logic [5:0]              cnt_q;
	stats_req_t              req_q;
	logic [NUM_W-1:0]        num_q;
	logic [CNT_W-1:0]        rem_q;
	logic [NUM_W-1:0]        a_q;
	logic [2*Q_W-1:0]        m2_q;
	logic [NUM_W:0]          sv_q;
	logic [ROOT_W-1:0]       root_q;
	logic [31:0]             srem_q;
	logic [NSIG_W+Q_W-1:0]   prod_q;
	logic signed [Q_W-1:0]   mean_q;
	logic [Q_W-1:0]          std_q;
	logic signed [Q_W-1:0]   cut_q;
	logic                    done_q;

	// divider step
	logic [CNT_W:0]   trial;
	logic             div_ge;
	logic [CNT_W-1:0] rem_nx;
	assign trial  = {rem_q, num_q[NUM_W-1]};
	assign div_ge = trial >= {1'b0, req_q.n};
	assign rem_nx = div_ge ? CNT_W'(trial - {1'b0, req_q.n}) : trial[CNT_W-1:0];

	// mean numerator from the sum magnitude of the incoming request
	logic             sum_neg;
	logic [SUM_W-1:0] sum_mag;
	assign sum_neg = req_q.sum[SUM_W-1];
	assign sum_mag = req.sum[SUM_W-1] ? SUM_W'(~req.sum + 1'b1) : req.sum;

	// floor of the signed mean, saturated
	logic [38:0]        qmag;
	logic signed [39:0] mean_full;
	logic signed [Q_W-1:0] mean_sat;
	always_comb begin
		qmag = {1'b0, num_q[37:0]} + 39'(sum_neg && (rem_q != '0));
		mean_full = sum_neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		priority if (mean_full > 40'(Q24_MAX)) mean_sat = Q24_MAX;
		else if (mean_full < 40'(Q24_MIN)) mean_sat = Q24_MIN;
		else mean_sat = mean_full[Q_W-1:0];
	end

	logic [Q_W-1:0] mean_mag;
	assign mean_mag = mean_q[Q_W-1] ? Q_W'(-mean_q) : mean_q;

	// variance, clamped at zero
	logic [NUM_W-1:0] var_v;
	assign var_v = (a_q > NUM_W'(m2_q)) ? (a_q - NUM_W'(m2_q)) : '0;

	// square root step, two bits per cycle
	logic [31:0] srem_sh;
	logic [31:0] s_trial;
	logic        s_ge;
	assign srem_sh = {srem_q[29:0], sv_q[NUM_W:NUM_W-1]};
	assign s_trial = {root_q, 2'b01};
	assign s_ge    = srem_sh >= s_trial;

	// cut level, saturated
	logic signed [29:0]     cut_full;
	logic signed [Q_W-1:0]  cut_sat;
	always_comb begin
		cut_full = 30'(mean_q) + $signed({2'b00, prod_q[NSIG_W+Q_W-1:8]});
		priority if (cut_full > 30'(Q24_MAX)) cut_sat = Q24_MAX;
		else if (cut_full < 30'(Q24_MIN)) cut_sat = Q24_MIN;
		else cut_sat = cut_full[Q_W-1:0];
	end

	// sequencer of the shared divider, root and cut units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DIVM;
						cnt_q   <= '0;
					end
				end
				S_DIVM, S_DIVA: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(NUM_W - 1)) begin
						state_q <= (state_q == S_DIVM) ? S_MFIN : S_AFIN;
					end
				end
				S_MFIN: begin
					state_q <= S_DIVA;
					cnt_q   <= '0;
				end
				S_AFIN: state_q <= S_VAR;
				S_VAR: begin
					state_q <= S_SQRT;
					cnt_q   <= '0;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(ROOT_W - 1)) begin
						state_q <= S_SFIN;
					end
				end
				S_SFIN: state_q <= S_CUTM;
				S_CUTM: state_q <= S_CUTA;
				S_CUTA: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q <= req;
					num_q <= NUM_W'({sum_mag, 8'h00});
					rem_q <= '0;
				end
			end
			S_DIVM, S_DIVA: begin
				num_q <= {num_q[NUM_W-2:0], div_ge};
				rem_q <= rem_nx;
			end
			S_MFIN: begin
				mean_q <= mean_sat;
				num_q  <= {req_q.sq, 16'h0000};
				rem_q  <= '0;
			end
			S_AFIN: begin
				a_q  <= num_q;
				m2_q <= mean_mag * mean_mag;
			end
			S_VAR: begin
				sv_q   <= {1'b0, var_v};
				root_q <= '0;
				srem_q <= '0;
			end
			S_SQRT: begin
				sv_q   <= {sv_q[NUM_W-2:0], 2'b00};
				srem_q <= s_ge ? (srem_sh - s_trial) : srem_sh;
				root_q <= {root_q[ROOT_W-2:0], s_ge};
			end
			S_SFIN: begin
				std_q <= (root_q > ROOT_W'({Q_W{1'b1}})) ? {Q_W{1'b1}} : root_q[Q_W-1:0];
			end
			S_CUTM: prod_q <= nsigma * std_q;
			S_CUTA: cut_q <= cut_sat;
			default: ;
		endcase
	end

	assign done     = done_q;
	assign res.mean = mean_q;
	assign res.std  = std_q;
	assign res.cut  = cut_q;

	`ISCL_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q)
	`ISCL_ASSERT_IMPL(a_rem_bound, clk, arst_n, (state_q == S_DIVM) || (state_q == S_DIVA), rem_q < req_q.n)
	`ISCL_ASSERT_IMPL(a_done_from_cut, clk, arst_n, done_q, $past(state_q) == S_CUTA)

endmodule

// ===== rtl/iterative_sigma_clip_threshold_unit.sv =====
`timescale 1ns / 1ps
`include "iterative_sigma_clip_threshold_unit_defines.svh"
// Sigma-clipping threshold unit over a 4096-entry pixel store.
// Input channel (pix_valid / pix_stall) carries one word: action, pixel_value,
// pixel_index. Action 0 stores a pixel, action 1 runs the statistics, action 2
// reads the mask bit of one pixel; action 3 is dropped.
// Output channel (res_valid / res_stall) carries one word per action 1 or 2.
// A load gives no word. A mask read gives its word through the MASK and EMIT
// states, once the output register is free. A compute walks the store once per
// pass through the registered RAM read port, clip_passes+1 passes in all, and each
// pass that keeps pixels is followed by the statistics unit (two 59-step serial
// divisions, a 30-step square root and six single steps).
// The unit takes one word at a time; pix_stall is high while a word is in
// work. A finished word waits in the output register while res_stall is high;
// loads are still taken then, a further result waits until the register frees.
// Reset clears control and statistics (cut at maximum, nothing masked) and
// loads the register defaults; the pixel store holds no reset value.
// Registers via APB at 0x0 nsigma_q8, 0x4 pixel_count, 0x8 clip_passes.
module iterative_sigma_clip_threshold_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [3:0]                             paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	input  logic                                   pix_valid,
	output logic                                   pix_stall,
	input  logic [1:0]                             action,
	input  logic signed [iscl_pkg::PIXEL_BITS-1:0] pixel_value,
	input  logic [iscl_pkg::ADDR_W-1:0]            pixel_index,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic                                   result_kind,
	output logic                                   mask_bit,
	output logic signed [iscl_pkg::Q_W-1:0]        mean_q8,
	output logic [iscl_pkg::Q_W-1:0]               std_q8,
	output logic signed [iscl_pkg::Q_W-1:0]        cut_q8,
	output logic [iscl_pkg::CNT_W-1:0]             kept_count
);
	import iscl_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MASK  = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_STATS = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	// configuration registers
	logic [NSIG_W-1:0] nsigma_q;
	logic [CNT_W-1:0]  count_q;
	logic [PASS_W-1:0] passes_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nsigma_q <= NSIGMA_RST;
			count_q  <= COUNT_RST;
			passes_q <= PASSES_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_NSIGMA: nsigma_q <= pwdata[NSIG_W-1:0];
				REG_COUNT:  count_q  <= pwdata[CNT_W-1:0];
				REG_PASSES: passes_q <= pwdata[PASS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_NSIGMA: prdata = {20'h0, nsigma_q};
			REG_COUNT:  prdata = {19'h0, count_q};
			REG_PASSES: prdata = {28'h0, passes_q};
			default:    prdata = '0;
		endcase
	end

	// control state
	logic [2:0]            state_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      addr_q;
	logic [PASS_W-1:0]     remain_q;
	logic                  first_q;
	logic                  pend_kind_q;
	logic                  pend_mask_q;

	// statistics levels
	logic signed [Q_W-1:0] mean_q;
	logic [Q_W-1:0]        std_q;
	logic signed [Q_W-1:0] cut_q;
	logic [CNT_W-1:0]      kept_q;

	// pass accumulators and walk pipeline
	logic                        rd_valid_s1;
	logic                        valid_s2;
	logic                        keep_s2;
	logic signed [PIXEL_BITS-1:0] p_s2;
	logic [2*PIXEL_BITS-1:0]     sq_s2;
	logic signed [SUM_W-1:0]     sum_q;
	logic [SQ_W-1:0]             sq_q;
	logic [CNT_W-1:0]            k_q;

	// output register
	logic                  res_valid_q;
	logic                  kind_q;
	logic                  mbit_q;
	logic signed [Q_W-1:0] omean_q;
	logic [Q_W-1:0]        ostd_q;
	logic signed [Q_W-1:0] ocut_q;
	logic [CNT_W-1:0]      okept_q;

	logic pix_acc;
	logic slot_free;
	assign pix_stall = state_q != ST_IDLE;
	assign pix_acc   = pix_valid && !pix_stall;
	assign slot_free = !res_valid_q || !res_stall;

	// pixel store
	logic                         ram_we;
	logic                         ram_re;
	logic [ADDR_W-1:0]            ram_raddr;
	logic signed [PIXEL_BITS-1:0] ram_rdata;

	assign ram_we    = pix_acc && (action == ACT_LOAD);
	assign ram_re    = (pix_acc && (action == ACT_MASK)) || (state_q == ST_WALK);
	assign ram_raddr = (state_q == ST_WALK) ? addr_q[ADDR_W-1:0] : pixel_index;

	iscl_pixel_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pixel_index),
		.wdata (pixel_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// statistics unit
	stats_req_t stat_req;
	stats_res_t stat_res;
	logic       stat_start;
	logic       stat_done;

	assign stat_req.n   = k_q;
	assign stat_req.sum = sum_q;
	assign stat_req.sq  = sq_q;
	assign stat_start   = (state_q == ST_DRAIN) && !rd_valid_s1 && !valid_s2 &&
		(first_q || (k_q != '0));

	iscl_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (stat_start),
		.req    (stat_req),
		.nsigma (nsigma_q),
		.done   (stat_done),
		.res    (stat_res)
	);

	// pixel compare against the scaled cut
	logic signed [Q_W-1:0] pix_scaled;
	logic                  pix_keep;
	assign pix_scaled = {ram_rdata, 8'h00};
	assign pix_keep   = first_q || (pix_scaled <= cut_q);

	// square stage and accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			rd_valid_s1 <= state_q == ST_WALK;
			valid_s2    <= rd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		keep_s2 <= pix_keep;
		p_s2    <= ram_rdata;
		sq_s2   <= (2*PIXEL_BITS)'(ram_rdata * ram_rdata);
	end

	// end-of-pass decision: next pass or emit
	logic pass_end;
	assign pass_end = ((state_q == ST_DRAIN) && !rd_valid_s1 && !valid_s2 && !stat_start) ||
		((state_q == ST_STATS) && stat_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			addr_q      <= '0;
			remain_q    <= '0;
			first_q     <= 1'b0;
			pend_kind_q <= KIND_STATS;
			pend_mask_q <= 1'b0;
			sum_q       <= '0;
			sq_q        <= '0;
			k_q         <= '0;
			mean_q      <= '0;
			std_q       <= '0;
			cut_q       <= Q24_MAX;
			kept_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// output word valid: loaded from emit, cleared when taken
			if ((state_q == ST_EMIT) && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (valid_s2 && keep_s2) begin
				sum_q <= sum_q + SUM_W'(p_s2);
				sq_q  <= sq_q + SQ_W'(sq_s2);
				k_q   <= k_q + 1'b1;
			end
			if (stat_done) begin
				mean_q <= stat_res.mean;
				std_q  <= stat_res.std;
				cut_q  <= stat_res.cut;
				kept_q <= k_q;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pix_acc && (action == ACT_MASK)) begin
						state_q <= ST_MASK;
					end else if (pix_acc && (action == ACT_COMPUTE)) begin
						priority if (count_q == '0) n_q <= CNT_W'(1);
						else if (count_q > CNT_W'(MAX_PIXELS)) n_q <= CNT_W'(MAX_PIXELS);
						else n_q <= count_q;
						addr_q   <= '0;
						remain_q <= passes_q;
						first_q  <= 1'b1;
						sum_q    <= '0;
						sq_q     <= '0;
						k_q      <= '0;
						state_q  <= ST_WALK;
					end
				end
				ST_MASK: begin
					pend_kind_q <= KIND_MASK;
					pend_mask_q <= pix_scaled > cut_q;
					state_q     <= ST_EMIT;
				end
				ST_WALK: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == n_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN, ST_STATS: begin
					if (stat_start) begin
						state_q <= ST_STATS;
					end else if (pass_end) begin
						if (remain_q == '0) begin
							pend_kind_q <= KIND_STATS;
							pend_mask_q <= 1'b0;
							state_q     <= ST_EMIT;
						end else begin
							remain_q <= remain_q - 1'b1;
							first_q  <= 1'b0;
							addr_q   <= '0;
							sum_q    <= '0;
							sq_q     <= '0;
							k_q      <= '0;
							state_q  <= ST_WALK;
						end
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && slot_free) begin
			kind_q <= pend_kind_q;
			mbit_q <= pend_mask_q;
			if (pend_kind_q == KIND_STATS) begin
				omean_q <= mean_q;
				ostd_q  <= std_q;
				ocut_q  <= cut_q;
				okept_q <= kept_q;
			end else begin
				omean_q <= '0;
				ostd_q  <= '0;
				ocut_q  <= '0;
				okept_q <= '0;
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign result_kind = kind_q;
	assign mask_bit    = mbit_q;
	assign mean_q8     = omean_q;
	assign std_q8      = ostd_q;
	assign cut_q8      = ocut_q;
	assign kept_count  = okept_q;

	`ISCL_ASSERT_IMPL(a_done_in_stats, clk, arst_n, stat_done, state_q == ST_STATS)
	`ISCL_ASSERT_IMPL(a_walk_bound, clk, arst_n, state_q == ST_WALK, addr_q < n_q)
	`ISCL_ASSERT_NEXT(a_emit_loads, clk, arst_n, (state_q == ST_EMIT) && slot_free, res_valid && (state_q == ST_IDLE))

endmodule
